[hdl/sysex_7bit_packer_with_crc16_defines.svh]
// ----------------------------------------------------------------------------
// SysEx 7-bit packer assertion macros
// Concurrent assertion helpers used by the packer back end.
// ----------------------------------------------------------------------------
`ifndef SYSEX_7BIT_PACKER_WITH_CRC16_DEFINES_SVH
`define SYSEX_7BIT_PACKER_WITH_CRC16_DEFINES_SVH
`ifndef SYNTHESIS
`define SX7_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sx7 assertion failed");
`define SX7_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sx7 assertion failed");
`else
`define SX7_ASSERT_IMP(lbl, ante, cons)
`define SX7_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/sx7_pkg.sv]
// ----------------------------------------------------------------------------
// SysEx 7-bit packer package
// Types, request codes, command format and the CRC-16/CCITT byte update.
// ----------------------------------------------------------------------------
package sx7_pkg;

  localparam int CHUNK_LEN     = 7;
  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  localparam logic [3:0] REQ_RAW       = 4'd0;
  localparam logic [3:0] REQ_PACK      = 4'd1;
  localparam logic [3:0] REQ_PACK_CRC  = 4'd2;
  localparam logic [3:0] REQ_PACK_SUM  = 4'd3;
  localparam logic [3:0] REQ_CRC_RESET = 4'd4;
  localparam logic [3:0] REQ_PK_INIT   = 4'd5;
  localparam logic [3:0] REQ_EMIT_CRC  = 4'd6;
  localparam logic [3:0] REQ_EMIT_SUM  = 4'd7;
  localparam logic [3:0] REQ_FLUSH     = 4'd8;

  typedef struct packed {
    logic [3:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_RAW,
    OP_PACK,
    OP_CRC_RESET,
    OP_PK_INIT,
    OP_EMIT_CRC,
    OP_EMIT_SUM,
    OP_FLUSH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       crc_en;
    logic       sum_en;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  x;
    logic [15:0] xw;
    x  = crc[15:8] ^ b;
    x  = x ^ (x >> 4);
    xw = {8'h00, x};
    return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
  endfunction

endpackage

[hdl/sx7_fifo.sv]
// ----------------------------------------------------------------------------
// SysEx 7-bit packer FIFO
// Small synchronous FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module sx7_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/sx7_front.sv]
// ----------------------------------------------------------------------------
// SysEx 7-bit packer front end
// Accepts requests, decodes the request type and queues commands.
// ----------------------------------------------------------------------------
module sx7_front (
  input  logic             in_push,
  input  sx7_pkg::in_item_t in_item,
  output logic             in_full,
  input  logic             cmd_full,
  output logic             cmd_push,
  output sx7_pkg::cmd_t    cmd
);

  logic known;

  assign in_full = cmd_full;

  always_comb begin
    known      = 1'b1;
    cmd.op     = sx7_pkg::OP_RAW;
    cmd.data   = in_item.data_byte;
    cmd.crc_en = 1'b0;
    cmd.sum_en = 1'b0;
    case (in_item.req_type)
      sx7_pkg::REQ_RAW:      cmd.op = sx7_pkg::OP_RAW;
      sx7_pkg::REQ_PACK:     cmd.op = sx7_pkg::OP_PACK;
      sx7_pkg::REQ_PACK_CRC: begin
        cmd.op     = sx7_pkg::OP_PACK;
        cmd.crc_en = 1'b1;
      end
      sx7_pkg::REQ_PACK_SUM: begin
        cmd.op     = sx7_pkg::OP_PACK;
        cmd.crc_en = 1'b1;
        cmd.sum_en = 1'b1;
      end
      sx7_pkg::REQ_CRC_RESET: cmd.op = sx7_pkg::OP_CRC_RESET;
      sx7_pkg::REQ_PK_INIT:  cmd.op = sx7_pkg::OP_PK_INIT;
      sx7_pkg::REQ_EMIT_CRC: cmd.op = sx7_pkg::OP_EMIT_CRC;
      sx7_pkg::REQ_EMIT_SUM: cmd.op = sx7_pkg::OP_EMIT_SUM;
      sx7_pkg::REQ_FLUSH:    cmd.op = sx7_pkg::OP_FLUSH;
      default:               known  = 1'b0;
    endcase
  end

  assign cmd_push = in_push && !cmd_full && known;

endmodule

[hdl/sx7_back.sv]
// ----------------------------------------------------------------------------
// SysEx 7-bit packer back end
// Executes queued commands and writes at most one stream byte per cycle, holding while the result queue is full.
// ----------------------------------------------------------------------------
`include "sysex_7bit_packer_with_crc16_defines.svh"

module sx7_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  sx7_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               out_full,
  output logic               wr_en,
  output sx7_pkg::out_item_t wr_item
);

  typedef enum logic [1:0] {S_IDLE, S_RAW, S_PACK, S_HIGH} state_t;

  state_t      state_r, state_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        more_r, more_nxt;
  logic        flush_r, flush_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic        crc_en_r, crc_en_nxt;
  logic        sum_en_r, sum_en_nxt;
  logic [7:0]  pk_hb;
  logic [2:0]  pk_cnt;
  logic        pk_wrap;

  assign pk_hb   = (hb_r | (byte_r & 8'h80)) >> 1;
  assign pk_cnt  = cnt_r + 3'd1;
  assign pk_wrap = (pk_cnt == 3'(sx7_pkg::CHUNK_LEN));

  always_comb begin
    state_nxt  = state_r;
    crc_nxt    = crc_r;
    sum_nxt    = sum_r;
    hb_nxt     = hb_r;
    cnt_nxt    = cnt_r;
    more_nxt   = more_r;
    flush_nxt  = flush_r;
    byte_nxt   = byte_r;
    lo_nxt     = lo_r;
    crc_en_nxt = crc_en_r;
    sum_en_nxt = sum_en_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_item    = '0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          more_nxt   = 1'b0;
          flush_nxt  = 1'b0;
          crc_en_nxt = cmd.crc_en;
          sum_en_nxt = cmd.sum_en;
          byte_nxt   = cmd.data;
          case (cmd.op)
            sx7_pkg::OP_RAW:  state_nxt = S_RAW;
            sx7_pkg::OP_PACK: state_nxt = S_PACK;
            sx7_pkg::OP_CRC_RESET: begin
              crc_nxt = sx7_pkg::CRC_PRESET;
              sum_nxt = '0;
            end
            sx7_pkg::OP_PK_INIT: begin
              hb_nxt  = '0;
              cnt_nxt = '0;
            end
            sx7_pkg::OP_EMIT_CRC: begin
              byte_nxt   = crc_r[15:8];
              lo_nxt     = crc_r[7:0];
              more_nxt   = 1'b1;
              crc_en_nxt = 1'b1;
              sum_en_nxt = 1'b0;
              state_nxt  = S_PACK;
            end
            sx7_pkg::OP_EMIT_SUM: begin
              byte_nxt   = sum_r;
              crc_en_nxt = 1'b0;
              sum_en_nxt = 1'b0;
              state_nxt  = S_PACK;
            end
            sx7_pkg::OP_FLUSH: begin
              if (cnt_r != '0) begin
                byte_nxt   = '0;
                crc_en_nxt = 1'b1;
                sum_en_nxt = 1'b0;
                flush_nxt  = 1'b1;
                state_nxt  = S_PACK;
              end
            end
            default: ;
          endcase
        end
      end
      S_RAW: begin
        if (!out_full) begin
          wr_en            = 1'b1;
          wr_item.out_byte = byte_r;
          wr_item.last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_PACK: begin
        if (!out_full) begin
          wr_en            = 1'b1;
          wr_item.out_byte = {1'b0, byte_r[6:0]};
          wr_item.last     = !pk_wrap && !more_r && !flush_r;
          hb_nxt           = pk_hb;
          cnt_nxt          = pk_wrap ? 3'd0 : pk_cnt;
          if (crc_en_r) begin
            crc_nxt = sx7_pkg::crc_feed(crc_r, byte_r);
          end
          if (sum_en_r) begin
            sum_nxt = sum_r + byte_r;
          end
          if (pk_wrap) begin
            state_nxt = S_HIGH;
          end else if (more_r) begin
            byte_nxt = lo_r;
            more_nxt = 1'b0;
          end else if (!flush_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_HIGH: begin
        if (!out_full) begin
          wr_en            = 1'b1;
          wr_item.out_byte = hb_r;
          wr_item.last     = !more_r;
          if (more_r) begin
            byte_nxt  = lo_r;
            more_nxt  = 1'b0;
            state_nxt = S_PACK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      crc_r   <= sx7_pkg::CRC_PRESET;
      sum_r   <= '0;
      hb_r    <= '0;
      cnt_r   <= '0;
      more_r  <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      sum_r   <= sum_nxt;
      hb_r    <= hb_nxt;
      cnt_r   <= cnt_nxt;
      more_r  <= more_nxt;
      flush_r <= flush_nxt;
    end
    byte_r   <= byte_nxt;
    lo_r     <= lo_nxt;
    crc_en_r <= crc_en_nxt;
    sum_en_r <= sum_en_nxt;
  end

  `SX7_ASSERT_IMP(a_no_write_full, wr_en, !out_full)
  `SX7_ASSERT_IMP(a_high_after_wrap, state_r == S_HIGH, cnt_r == 3'd0)
  `SX7_ASSERT_IMP(a_flush_open, (state_r == S_PACK) && flush_r, cnt_r != 3'd0)
  `SX7_ASSERT_IMP(a_more_busy, more_r, (state_r == S_PACK) || (state_r == S_HIGH))
  `SX7_ASSERT_NEXT(a_pop_leaves_idle, cmd_pop && (state_r == S_IDLE), !more_r || !flush_r)

endmodule

[hdl/sysex_7bit_packer_with_crc16.sv]
// Path: a request's first byte passes the command queue, the back end's command load and the result queue.
// The back end loads a command only when idle, then writes its bytes; it takes no new command until done.
// Init requests and empty flushes finish in the back end's idle state; unknown types never reach it.
// The sequencer writes at most one byte per cycle into the result queue.
// Reset: synchronous, active low; CRC goes to 0xFFFF, sum and packer clear, queues empty.
// ----------------------------------------------------------------------------
// SysEx 7-bit packer with CRC-16 top level
// Front decoder, command queue, execution back end and result queue.
// ----------------------------------------------------------------------------
module sysex_7bit_packer_with_crc16 #(
  parameter int CMD_DEPTH = sx7_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = sx7_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sx7_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output sx7_pkg::out_item_t out_item
);

  sx7_pkg::cmd_t      fe_cmd;
  sx7_pkg::cmd_t      q_cmd;
  logic               cmd_push;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               res_full;
  logic               res_wr;
  sx7_pkg::out_item_t res_item;

  sx7_front u_front (
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (fe_cmd)
  );

  sx7_fifo #(
    .W     ($bits(sx7_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (fe_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (q_cmd),
    .empty   (cmd_empty)
  );

  sx7_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (q_cmd),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .wr_en     (res_wr),
    .wr_item   (res_item)
  );

  sx7_fifo #(
    .W     ($bits(sx7_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule
